[rtl/assert_macros.svh]
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CCQ_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define CCQ_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ccq_pkg.sv]
`default_nettype none

package ccq_pkg;

    // Field widths and fixed constants of the coordinate format
    localparam int MAX_BANDS_DEF = 18;
    localparam int VALUE_W       = 40;
    localparam int WIDTH_REG_W   = 4;
    localparam int MANT_W        = 8;
    localparam int EXP_W         = 4;
    localparam int MASTER_W      = 2;
    localparam int BAND_W        = 5;
    localparam int SHIFT_W       = 6;
    localparam int JOB_CNT_W     = 7;   // holds a band count up to the largest store size
    localparam int FRAC_BITS     = 38;
    localparam int MSB_LIMIT     = FRAC_BITS - 1;
    localparam int ESCAPE_EXP    = 15;
    localparam int TOP_MASTER    = 3;
    localparam int MANT_MIN      = 1;
    localparam int MANT_MAX      = 8;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 4'd4;

    // One finished channel handed from the front to the back
    typedef struct packed {
        logic                  bank;
        logic [JOB_CNT_W-1:0]  count;
        logic [MASTER_W-1:0]   master;
        logic [WIDTH_REG_W-1:0] width;
    } job_t;

    // Status of the job queue
    typedef struct packed {
        logic       valid;
        logic       full;
        logic [1:0] occupancy;
    } q_status_t;

    // Leading-one shift of a nonzero value: max(0, 37 - msb)
    function automatic logic [SHIFT_W-1:0] lead_shift(logic [VALUE_W-1:0] v);
        logic [SHIFT_W-1:0] msb;
        msb = '0;
        for (int b = 0; b < VALUE_W; b++) begin
            if (v[b]) begin
                msb = SHIFT_W'(b);
            end
        end
        return (msb >= SHIFT_W'(MSB_LIMIT)) ? '0 : SHIFT_W'(MSB_LIMIT) - msb;
    endfunction

    // Master exponent: shift divided by three, clamped; zero gives the top value
    function automatic logic [MASTER_W-1:0] master_of(logic [VALUE_W-1:0] loud);
        logic [SHIFT_W-1:0] s;
        s = lead_shift(loud);
        if (loud == '0) begin
            return MASTER_W'(TOP_MASTER);
        end
        if (s >= SHIFT_W'(3 * TOP_MASTER)) begin
            return MASTER_W'(TOP_MASTER);
        end
        if (s >= SHIFT_W'(6)) begin
            return MASTER_W'(2);
        end
        if (s >= SHIFT_W'(3)) begin
            return MASTER_W'(1);
        end
        return '0;
    endfunction

    // Mantissa width as used: out-of-range codes clamp to 1..8
    function automatic logic [WIDTH_REG_W-1:0] eff_width(logic [WIDTH_REG_W-1:0] w);
        if (w < WIDTH_REG_W'(MANT_MIN)) begin
            return WIDTH_REG_W'(MANT_MIN);
        end
        if (w > WIDTH_REG_W'(MANT_MAX)) begin
            return WIDTH_REG_W'(MANT_MAX);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/ccq_ram.sv]
`default_nettype none

module ccq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry into a register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/ccq_front.sv]
`default_nettype none

module ccq_front
    import ccq_pkg::*;
#(
    parameter int MAX_BANDS = MAX_BANDS_DEF,
    parameter int IDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
    parameter int CNT_W = $clog2(MAX_BANDS + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [WIDTH_REG_W-1:0] cfg_wdata,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic [VALUE_W-1:0]     coord_value,
    input  wire logic                   is_last,
    input  wire logic                   q_full,
    output logic                        push,
    output job_t                        push_job,
    output logic                        wr_en,
    output logic [IDX_W:0]              wr_addr,
    output logic [VALUE_W-1:0]          wr_data
);

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VALUE_W-1:0]     loud_reg, loud_next;
    logic                   bank_reg;
    logic                   fin_pending_reg;
    logic [VALUE_W-1:0]     fin_loud_reg;
    logic [CNT_W-1:0]       fin_count_reg;
    logic [WIDTH_REG_W-1:0] fin_width_reg;

    logic accept;
    logic store;

    // Take an item unless a finished channel still waits for the queue or the queue is full
    assign item_ready = !fin_pending_reg && !q_full;
    assign accept     = item_valid && item_ready;
    assign store      = accept && (count_reg < CNT_W'(MAX_BANDS));

    // Track the count and the loudest value; drop items beyond the store
    always_comb
    begin
        count_next = count_reg;
        loud_next  = loud_reg;
        if (store)
        begin
            count_next = count_reg + CNT_W'(1);
            if (coord_value > loud_reg)
            begin
                loud_next = coord_value;
            end
        end
    end

    // Write the value into the bank being filled
    assign wr_en   = store;
    assign wr_addr = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data = coord_value;

    // Hand the finished channel to the queue in the cycle after its last item
    assign push            = fin_pending_reg;
    assign push_job.bank   = bank_reg;
    assign push_job.count  = JOB_CNT_W'(fin_count_reg);
    assign push_job.master = master_of(fin_loud_reg);
    assign push_job.width  = fin_width_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_RESET;
            count_reg       <= '0;
            loud_reg        <= '0;
            bank_reg        <= 1'b0;
            fin_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end
            if (accept && is_last)
            begin
                count_reg       <= '0;
                loud_reg        <= '0;
                fin_pending_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_next;
                loud_reg  <= loud_next;
                if (fin_pending_reg)
                begin
                    fin_pending_reg <= 1'b0;
                    bank_reg        <= ~bank_reg;
                end
            end
        end
    end

    // Capture the channel summary on its last item
    always_ff @(posedge clk)
    begin
        if (accept && is_last)
        begin
            fin_loud_reg  <= loud_next;
            fin_count_reg <= count_next;
            fin_width_reg <= eff_width(width_reg);
        end
    end

endmodule

`default_nettype wire

[rtl/ccq_job_queue.sv]
`default_nettype none

module ccq_job_queue
    import ccq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output q_status_t stat
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] occ_reg;

    assign head           = slot_reg[rd_ptr_reg];
    assign stat.valid     = (occ_reg != 2'd0);
    assign stat.full      = (occ_reg == 2'd2);
    assign stat.occupancy = occ_reg;

    // Store a pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                occ_reg <= occ_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                occ_reg <= occ_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/ccq_back.sv]
`default_nettype none

module ccq_back
    import ccq_pkg::*;
#(
    parameter int IDX_W = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire job_t                head,
    output logic                     pop,
    output logic                     rd_en,
    output logic [IDX_W:0]           rd_addr,
    input  wire logic [VALUE_W-1:0]  rd_data,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [MASTER_W-1:0]      master_exp,
    output logic [BAND_W-1:0]        band_index,
    output logic [EXP_W-1:0]         coord_exp,
    output logic [MANT_W-1:0]        coord_mant,
    output logic                     last_out
);

    typedef struct packed {
        logic [MASTER_W-1:0]    master;
        logic [WIDTH_REG_W-1:0] width;
        logic [BAND_W-1:0]      band;
        logic                   last;
    } meta_t;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_LOUD,
        CLS_QUIET,
        CLS_NORMAL
    } cls_t;

    localparam int R_W = 12;

    logic en;
    logic issue;
    logic issue_last;

    logic [IDX_W-1:0]        rd_idx_reg;
    logic [JOB_CNT_W-1:0]    idx_ext;
    logic [IDX_W+BAND_W-1:0] band_ext;

    logic               p0_valid_reg;
    meta_t              p0_meta_reg;
    logic               a_valid_reg;
    meta_t              a_meta_reg;
    logic [VALUE_W-1:0] a_v_reg;
    logic [SHIFT_W-1:0] a_s_reg;
    logic               b_valid_reg;
    meta_t              b_meta_reg;
    logic [VALUE_W-1:0] b_v_reg;
    logic [SHIFT_W-1:0] b_k_reg;
    logic [EXP_W-1:0]   b_e_reg;
    cls_t               b_cls_reg;

    logic                out_valid_reg;
    logic [MASTER_W-1:0] master_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [EXP_W-1:0]    exp_reg;
    logic [MANT_W-1:0]   mant_reg;
    logic                last_reg;

    logic [6:0]   three_m;
    logic [6:0]   e_raw;
    logic [6:0]   k_normal;
    logic [6:0]   k_quiet;
    logic [5:0]   k_sel;
    cls_t         cls_sel;

    logic [VALUE_W:0]   sum;
    logic [VALUE_W:0]   shifted;
    logic [R_W-1:0]     r;
    logic [8:0]         top9;
    logic               ovf;
    logic [EXP_W-1:0]   exp_c;
    logic [MANT_W-1:0]  mant_c;

    // Whole back end advances when the output register is free or being taken
    assign en = !out_valid_reg || result_ready;

    // Issue one stored value per cycle, while the back end advances, from the job at the head of the queue
    assign issue      = en && q_valid;
    assign idx_ext    = JOB_CNT_W'(rd_idx_reg);
    assign issue_last = ((idx_ext + JOB_CNT_W'(1)) == head.count);
    assign pop        = issue && issue_last;
    assign rd_en      = issue;
    assign rd_addr    = {head.bank, rd_idx_reg};
    assign band_ext   = {{BAND_W{1'b0}}, rd_idx_reg};

    // Classify from shift and master, and pick the rounding position
    always_comb
    begin
        three_m  = 7'(a_meta_reg.master) * 7'd3;
        e_raw    = {1'b0, a_s_reg} - three_m;
        k_normal = 7'(MSB_LIMIT) - {1'b0, a_s_reg} - 7'(a_meta_reg.width);
        k_quiet  = 7'(FRAC_BITS - ESCAPE_EXP) - three_m - 7'(a_meta_reg.width);
        k_sel    = k_normal[5:0];
        if (a_v_reg == '0)
        begin
            cls_sel = CLS_ZERO;
        end
        else if (e_raw[6])
        begin
            cls_sel = CLS_LOUD;
        end
        else if (e_raw >= 7'(ESCAPE_EXP))
        begin
            cls_sel = CLS_QUIET;
            k_sel   = k_quiet[5:0];
        end
        else
        begin
            cls_sel = CLS_NORMAL;
        end
    end

    // Round half up at the chosen position and form exponent and mantissa
    always_comb
    begin
        sum     = {1'b0, b_v_reg} + ((VALUE_W + 1)'(1) << (b_k_reg - SHIFT_W'(1)));
        shifted = sum >> b_k_reg;
        r       = shifted[R_W-1:0];
        top9    = (9'd1 << b_meta_reg.width) - 9'd1;
        ovf     = (r >> (b_meta_reg.width + WIDTH_REG_W'(1))) != '0;
        exp_c   = b_e_reg;
        mant_c  = '0;
        unique case (b_cls_reg)
            CLS_ZERO:
            begin
                exp_c  = EXP_W'(ESCAPE_EXP);
                mant_c = '0;
            end
            CLS_LOUD:
            begin
                exp_c  = '0;
                mant_c = top9[MANT_W-1:0];
            end
            CLS_QUIET:
            begin
                exp_c  = EXP_W'(ESCAPE_EXP);
                mant_c = (r > R_W'(top9)) ? top9[MANT_W-1:0] : r[MANT_W-1:0];
            end
            CLS_NORMAL:
            begin
                // Rounding carry: move up one binade, or saturate at exponent zero
                if (ovf)
                begin
                    if (b_e_reg == '0)
                    begin
                        exp_c  = '0;
                        mant_c = top9[MANT_W-1:0];
                    end
                    else
                    begin
                        exp_c  = b_e_reg - EXP_W'(1);
                        mant_c = '0;
                    end
                end
                else
                begin
                    exp_c  = b_e_reg;
                    mant_c = r[MANT_W-1:0] & top9[MANT_W-1:0];
                end
            end
            default:
            begin
                exp_c  = b_e_reg;
                mant_c = '0;
            end
        endcase
    end

    // Valid bits and read index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            p0_valid_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (issue)
            begin
                rd_idx_reg <= issue_last ? '0 : rd_idx_reg + IDX_W'(1);
            end
            p0_valid_reg  <= issue;
            a_valid_reg   <= p0_valid_reg;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // Payload through the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (issue)
            begin
                p0_meta_reg.master <= head.master;
                p0_meta_reg.width  <= head.width;
                p0_meta_reg.band   <= band_ext[BAND_W-1:0];
                p0_meta_reg.last   <= issue_last;
            end
            a_meta_reg <= p0_meta_reg;
            a_v_reg    <= rd_data;
            a_s_reg    <= lead_shift(rd_data);
            b_meta_reg <= a_meta_reg;
            b_v_reg    <= a_v_reg;
            b_k_reg    <= k_sel;
            b_e_reg    <= e_raw[EXP_W-1:0];
            b_cls_reg  <= cls_sel;
            if (b_valid_reg)
            begin
                master_reg <= b_meta_reg.master;
                band_reg   <= b_meta_reg.band;
                exp_reg    <= exp_c;
                mant_reg   <= mant_c;
                last_reg   <= b_meta_reg.last;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign master_exp   = master_reg;
    assign band_index   = band_reg;
    assign coord_exp    = exp_reg;
    assign coord_mant   = mant_reg;
    assign last_out     = last_reg;

endmodule

`default_nettype wire

[rtl/coupling_coordinate_quantizer_unit.sv]
// Coupling coordinate quantizer.
// Item channel: item_valid/item_ready with coord_value (unsigned Q2.38) and
// is_last. One item is taken per cycle while a channel is being collected and
// the job queue has room; after the item marked last the front pauses while
// it picks the master exponent. Values beyond MAX_BANDS are dropped.
// Result channel: result_valid/result_ready, one item per stored band with
// master_exp, band_index, coord_exp, coord_mant and last_out on the final one.
// Results of a channel follow its last item through the queue, the single read
// port of the value store and the three-stage quantizing pipeline behind it,
// one per cycle while the receiver keeps taking them.
// The store is double-banked and a two-entry job queue sits between the
// collecting front and the emitting back, so the next channel is collected
// while the previous one drains; the front stalls only in its pause after a
// last item and when two finished channels are waiting.
// A stalled receiver freezes the back pipeline and holds the result steady.
// Reset empties the queue and pipeline and sets the mantissa width to four;
// the value store itself is not cleared.
`default_nettype none

`include "assert_macros.svh"

module coupling_coordinate_quantizer_unit
    import ccq_pkg::*;
#(
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [WIDTH_REG_W-1:0] cfg_wdata,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic [VALUE_W-1:0]     coord_value,
    input  wire logic                   is_last,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic [MASTER_W-1:0]         master_exp,
    output logic [BAND_W-1:0]           band_index,
    output logic [EXP_W-1:0]            coord_exp,
    output logic [MANT_W-1:0]           coord_mant,
    output logic                        last_out
);

    localparam int IDX_W     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CNT_W     = $clog2(MAX_BANDS + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    logic               q_push;
    job_t               q_push_job;
    logic               q_pop;
    job_t               q_head;
    q_status_t          q_stat;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;
    logic               in_take;

    // Collect values and pick the master exponent
    ccq_front #(
        .MAX_BANDS (MAX_BANDS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .coord_value (coord_value),
        .is_last     (is_last),
        .q_full      (q_stat.full),
        .push        (q_push),
        .push_job    (q_push_job),
        .wr_en       (ram_wr_en),
        .wr_addr     (ram_wr_addr),
        .wr_data     (ram_wr_data)
    );

    // Double-banked value store
    ccq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Finished channels waiting for the back end
    ccq_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // Quantize stored values and emit results
    ccq_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_stat.valid),
        .head         (q_head),
        .pop          (q_pop),
        .rd_en        (ram_rd_en),
        .rd_addr      (ram_rd_addr),
        .rd_data      (ram_rd_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .master_exp   (master_exp),
        .band_index   (band_index),
        .coord_exp    (coord_exp),
        .coord_mant   (coord_mant),
        .last_out     (last_out)
    );

    // Item handshake as seen by the checks
    assign in_take = item_valid && item_ready;

    // Queue never holds more than its two slots
    `CCQ_ASSERT(a_q_occupancy, clk, rst_n, q_stat.occupancy <= 2'd2, "job queue overfilled")
    // Front takes no item while both banks are claimed
    `CCQ_ASSERT(a_accept_room, clk, rst_n, in_take |-> !q_stat.full, "item taken with queue full")
    // Back only releases a job that exists
    `CCQ_ASSERT(a_pop_valid, clk, rst_n, q_pop |-> q_stat.valid, "pop from empty job queue")
    // A pushed job is visible to the back in the next cycle
    `CCQ_ASSERT_NEXT(a_push_seen, clk, rst_n, q_push, q_stat.valid, "pushed job lost")

endmodule

`default_nettype wire

[sim/coupling_coordinate_quantizer_unit_test.sv]
`default_nettype none

module coupling_coordinate_quantizer_unit_test;
    import ccq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_GOAL  = 45;
    localparam int HOLD_AFTER  = 120;
    localparam int HOLD_START  = 4;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // One quantized band as it leaves the block
    typedef struct packed {
        logic [MASTER_W-1:0] master;
        logic [BAND_W-1:0]   band;
        logic [EXP_W-1:0]    expo;
        logic [MANT_W-1:0]   mant;
        logic                closes;
    } coord_pair_t;

    // Mirror of the channel store; turns each closing item into its band pairs
    class coord_scoreboard;
        logic [VALUE_W-1:0]     band_values[MAX_BANDS_DEF];
        int                     band_count;
        logic [VALUE_W-1:0]     peak_value;
        logic [WIDTH_REG_W-1:0] width_reg;
        coord_pair_t            awaited[$];
        int                     errors;

        function new();
            band_count = 0;
            peak_value = '0;
            width_reg  = WIDTH_RESET;
            errors     = 0;
        endfunction

        function void load_width(logic [WIDTH_REG_W-1:0] w);
            width_reg = w;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Leading-one distance below bit 37, zero for the top binades
        function int lead_gap(logic [VALUE_W-1:0] v);
            int hi;
            hi = 0;
            for (int b = 0; b < VALUE_W; b++) begin
                if (v[b]) begin
                    hi = b;
                end
            end
            return (hi >= MSB_LIMIT) ? 0 : MSB_LIMIT - hi;
        endfunction

        function bit [63:0] round_half_up(bit [63:0] x, int k);
            return (x + (64'd1 << (k - 1))) >> k;
        endfunction

        function void quantize(input logic [VALUE_W-1:0] v, input int master, input int m,
                               output logic [EXP_W-1:0] expo, output logic [MANT_W-1:0] mant);
            bit [63:0] full;
            bit [63:0] lead;
            bit [63:0] r;
            int        s;
            int        e;
            int        k;
            full = (64'd1 << m) - 64'd1;
            lead = 64'd1 << m;
            if (v == '0) begin
                expo = EXP_W'(ESCAPE_EXP);
                mant = '0;
                return;
            end
            s = lead_gap(v);
            e = s - 3 * master;
            if (e < 0) begin
                expo = '0;
                mant = MANT_W'(full);
                return;
            end
            // Plain-fraction escape for quiet values
            if (e >= ESCAPE_EXP) begin
                k = FRAC_BITS - ESCAPE_EXP - 3 * master - m;
                r = round_half_up(64'(v), k);
                if (r > full) begin
                    r = full;
                end
                expo = EXP_W'(ESCAPE_EXP);
                mant = MANT_W'(r);
                return;
            end
            k = MSB_LIMIT - s - m;
            r = round_half_up(64'(v), k);
            r = (r < lead) ? 64'd0 : r - lead;
            // Rounding carried into the next binade
            if (r > full) begin
                if (e == 0) begin
                    expo = '0;
                    mant = MANT_W'(full);
                    return;
                end
                e = e - 1;
                r = round_half_up(64'(v), k + 1);
                r = (r < lead) ? 64'd0 : r - lead;
            end
            if (r > full) begin
                r = full;
            end
            expo = EXP_W'(e);
            mant = MANT_W'(r);
        endfunction

        // Store the value; on the closing item queue one pair per stored band
        function void note_item(logic [VALUE_W-1:0] v, logic closing);
            int          m;
            int          master;
            coord_pair_t p;
            if (band_count < MAX_BANDS_DEF) begin
                band_values[band_count] = v;
                band_count++;
                if (v > peak_value) begin
                    peak_value = v;
                end
            end
            if (!closing) begin
                return;
            end
            m = int'(width_reg);
            if (m < MANT_MIN) begin
                m = MANT_MIN;
            end
            if (m > MANT_MAX) begin
                m = MANT_MAX;
            end
            if (peak_value == '0) begin
                master = TOP_MASTER;
            end
            else begin
                master = lead_gap(peak_value) / 3;
                if (master > TOP_MASTER) begin
                    master = TOP_MASTER;
                end
            end
            for (int i = 0; i < band_count; i++) begin
                p.master = MASTER_W'(master);
                p.band   = BAND_W'(i);
                quantize(band_values[i], master, m, p.expo, p.mant);
                p.closes = (i + 1 == band_count);
                awaited.push_back(p);
            end
            band_count = 0;
            peak_value = '0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) begin
                $display("MISMATCH %s", what);
            end
        endtask

        task check_result(coord_pair_t got);
            coord_pair_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected pair: band %0d exp %0d mant %0d",
                                 got.band, got.expo, got.mant));
                return;
            end
            want = awaited.pop_front();
            if (got.master !== want.master || got.band !== want.band ||
                got.expo !== want.expo || got.mant !== want.mant ||
                got.closes !== want.closes) begin
                report($sformatf("got/want m %0d/%0d b %0d/%0d e %0d/%0d mt %0d/%0d l %0d/%0d",
                                 got.master, want.master, got.band, want.band,
                                 got.expo, want.expo, got.mant, want.mant,
                                 got.closes, want.closes));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [WIDTH_REG_W-1:0] cfg_wdata;
    logic                   item_valid;
    logic                   item_ready;
    logic [VALUE_W-1:0]     coord_value;
    logic                   is_last;
    logic                   result_valid;
    logic                   result_ready;
    logic [MASTER_W-1:0]    master_exp;
    logic [BAND_W-1:0]      band_index;
    logic [EXP_W-1:0]       coord_exp;
    logic [MANT_W-1:0]      coord_mant;
    logic                   last_out;

    coord_scoreboard sb;
    coord_pair_t     seen_pair;
    int              burst_left;
    int              gap_len;
    bit              steady;
    int              cycles;
    int              sent;

    coupling_coordinate_quantizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .coord_value  (coord_value),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .master_exp   (master_exp),
        .band_index   (band_index),
        .coord_exp    (coord_exp),
        .coord_mant   (coord_mant),
        .last_out     (last_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Note accepted items and check accepted pairs
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (item_valid && item_ready) begin
                sb.note_item(coord_value, is_last);
            end
            if (result_valid && result_ready) begin
                seen_pair.master = master_exp;
                seen_pair.band   = band_index;
                seen_pair.expo   = coord_exp;
                seen_pair.mant   = coord_mant;
                seen_pair.closes = last_out;
                sb.check_result(seen_pair);
            end
        end
    end

    // Receiver: stall in random modes, with one long hold-off at the start of a
    // phase once output is flowing, so the sender keeps offering and fills the block
    initial
    begin
        rx_mode_t    mode;
        int          span;
        int          taken;
        int          hold_left;
        int          step;
        bit          held;
        logic [15:0] mask;
        logic        nxt;
        taken        = 0;
        hold_left    = 0;
        step         = 0;
        held         = 1'b0;
        result_ready = 1'b0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 2));
            span = $urandom_range(20, 150);
            mask = 16'($urandom) | 16'h1;
            repeat (span) begin
                @(posedge clk);
                if (result_valid && result_ready) begin
                    taken++;
                end
                if (!held && taken >= HOLD_AFTER && sent < HOLD_START) begin
                    held      = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
                step++;
                if (hold_left > 0) begin
                    hold_left--;
                    nxt = 1'b0;
                end
                else begin
                    case (mode)
                        RX_OPEN:   nxt = 1'b1;
                        RX_RANDOM: nxt = 1'($urandom_range(0, 1));
                        default:   nxt = mask[step % 16];
                    endcase
                end
                result_ready <= nxt;
            end
        end
    end

    // Give up on a hung run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one item and hold it until taken
    task automatic offer(input logic [VALUE_W-1:0] v, input logic closing);
        item_valid  <= 1'b1;
        coord_value <= v;
        is_last     <= closing;
        @(posedge clk);
        while (!item_ready) begin
            @(posedge clk);
        end
    endtask

    // Drop valid for a random gap at the end of each burst, unless the phase is steady
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_len    = steady ? 0 : $urandom_range(1, 8);
            if (gap_len > 0) begin
                item_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
    endtask

    // Hold the sender until every band pair is out, then let the pipe settle
    task automatic drain();
        item_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (sb.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_REG_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.load_width(w);
    endtask

    function automatic logic [VALUE_W-1:0] make_value(int scale);
        logic [VALUE_W-1:0] raw;
        raw = {8'($urandom), 32'($urandom)};
        case ($urandom_range(0, 9))
            0:       return '0;
            // runs of ones sit right on a rounding carry
            1:       return (VALUE_W'(1) << $urandom_range(1, VALUE_W)) - VALUE_W'(1);
            2:       return raw;
            3:       return raw >> $urandom_range(0, VALUE_W - 1);
            default: return raw >> (scale + $urandom_range(0, 8));
        endcase
    endfunction

    function automatic int channel_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return $urandom_range(MAX_BANDS_DEF + 1, MAX_BANDS_DEF + 4);
        end
        if (r == 1) begin
            return $urandom_range(13, MAX_BANDS_DEF);
        end
        return $urandom_range(1, 12);
    endfunction

    initial
    begin
        logic [VALUE_W-1:0]     loud_set[6];
        logic [WIDTH_REG_W-1:0] w;
        int                     len;
        int                     scale;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        item_valid  = 1'b0;
        coord_value = '0;
        is_last     = 1'b0;
        burst_left  = 0;
        gap_len     = 0;
        steady      = 1'b0;
        sent        = 0;
        sb          = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Silent channel: zero peak forces the top master
        offer('0, 1'b1);
        pace();

        // Loud channel: full scale, carries at exponents 0 and 1, clamped escape, tiny, zero
        loud_set = '{40'hFF_FFFF_FFFF, 40'h3F_FFFF_FFFF, 40'h1F_FFFF_FFFF,
                     40'h00_007F_FFFF, 40'h00_0000_0001, 40'h00_0000_0000};
        for (int i = 0; i < 6; i++) begin
            offer(loud_set[i], i == 5);
            pace();
        end

        // Overfull channel: quiet bands fill the store, loud extras are dropped
        for (int i = 0; i < MAX_BANDS_DEF; i++) begin
            offer(make_value(12 + $urandom_range(0, 20)) >> 12, 1'b0);
            pace();
        end
        offer(40'hFF_FFFF_FFFF, 1'b0);
        pace();
        offer(40'hFF_FFFF_FFFF, 1'b1);
        drain();

        // Random channels over a sweep of mantissa widths
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       w = 4'd0;
                1:       w = 4'd8;
                2:       w = 4'd1;
                3:       w = 4'd15;
                default: w = 4'($urandom_range(0, 15));
            endcase
            write_width(w);
            steady = ($urandom_range(0, 3) == 0);
            sent   = 0;
            while (sent < PHASE_GOAL) begin
                len   = channel_len();
                scale = $urandom_range(0, 34);
                for (int i = 0; i < len; i++) begin
                    offer(make_value(scale), i == len - 1);
                    sent++;
                    if (!(i == len - 1 && sent >= PHASE_GOAL)) begin
                        pace();
                    end
                end
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("end of test: clean");
        end
        else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

[coupling_coordinate_quantizer_unit.f]
+incdir+rtl
rtl/ccq_pkg.sv
rtl/ccq_ram.sv
rtl/ccq_front.sv
rtl/ccq_job_queue.sv
rtl/ccq_back.sv
rtl/coupling_coordinate_quantizer_unit.sv
sim/coupling_coordinate_quantizer_unit_test.sv
